// ----- rtl/core/tksel_pkg.sv -----
package tksel_pkg;

  localparam int unsigned SCORE_W    = 32;
  localparam int unsigned OUT_IDX_W  = 16;
  localparam int unsigned KEEP_W     = 7;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [OUT_IDX_W-1:0] out_idx_t;

  // signed order of two Q8.24 scores
  function automatic logic score_less(input score_t a, input score_t b);
    score_less = $signed(a) < $signed(b);
  endfunction

endpackage

// ----- rtl/core/tksel_ram.sv -----
module tksel_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/core/streaming_top_k_score_selector.sv -----
// An eviction adds a rescan of the store through one comparator and one RAM read
// port.
// One request is worked at a time; the next is taken once the result is registered.
// Reset (rst_ni low, asynchronous) empties the store, clears the arrival counter
// and sets keep_count to 64. Store contents are not cleared.
module streaming_top_k_score_selector #(
  parameter int unsigned MAX_KEEP   = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] score
  input  tksel_pkg::score_t                 s_axis_tdata,
  // [0] start_scan
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] item_index, [16] admitted, [17] evicted_valid, [33:18] evicted_index
  output logic [tksel_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tksel_pkg::KEEP_W-1:0]      cfg_data_i
);

  import tksel_pkg::*;

  localparam int unsigned SLOT_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_KEEP + 1);
  localparam int unsigned ENTRY_W = SCORE_W + INDEX_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [KEEP_W-1:0]     keep_q;
  logic [FILL_W-1:0]     filled_q, filled_d;
  logic [INDEX_BITS:0]   cnt_q, cnt_d;
  logic [SLOT_W-1:0]     min_slot_q, min_slot_d;
  score_t                min_score_q, min_score_d;
  logic [INDEX_BITS-1:0] min_item_q, min_item_d;
  logic [FILL_W-1:0]     issue_q, issue_d;
  logic                  rd_valid_q, rd_valid_d;
  logic [SLOT_W-1:0]     rd_slot_q, rd_slot_d;
  logic                  best_any_q, best_any_d;
  logic                  out_valid_q, out_valid_d;

  score_t                score_q;
  out_idx_t              res_index_q, res_index_d;
  logic                  res_adm_q, res_adm_d;
  logic                  res_ev_q, res_ev_d;
  out_idx_t              res_ev_idx_q, res_ev_idx_d;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic [31:0]                     keep_ext;
  logic [FILL_W-1:0]               k_eff;
  logic [INDEX_BITS-1:0]           idx;
  logic [INDEX_BITS+OUT_IDX_W-1:0] idx_ext;
  logic [INDEX_BITS+OUT_IDX_W-1:0] min_item_ext;
  score_t                          rd_score;
  logic [INDEX_BITS-1:0]           rd_item;
  logic                            take;
  logic                            in_acc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // clamp K to 1..MAX_KEEP
  assign keep_ext = {{(32 - KEEP_W){1'b0}}, keep_q};
  always_comb begin
    if (keep_ext == 32'd0) begin
      k_eff = FILL_W'(1);
    end else if (keep_ext > MAX_KEEP) begin
      k_eff = FILL_W'(MAX_KEEP);
    end else begin
      k_eff = FILL_W'(keep_ext);
    end
  end

  assign idx          = cnt_q[INDEX_BITS-1:0];
  assign idx_ext      = {{OUT_IDX_W{1'b0}}, idx};
  assign min_item_ext = {{OUT_IDX_W{1'b0}}, min_item_q};
  assign rd_score     = ram_rdata[SCORE_W-1:0];
  assign rd_item      = ram_rdata[ENTRY_W-1:SCORE_W];
  assign take = !best_any_q || score_less(rd_score, min_score_q) ||
                ((rd_score == min_score_q) && (rd_item < min_item_q));

  always_comb begin
    state_d      = state_q;
    filled_d     = filled_q;
    cnt_d        = cnt_q;
    min_slot_d   = min_slot_q;
    min_score_d  = min_score_q;
    min_item_d   = min_item_q;
    issue_d      = issue_q;
    rd_valid_d   = 1'b0;
    rd_slot_d    = rd_slot_q;
    best_any_d   = best_any_q;
    out_valid_d  = out_valid_q;
    res_index_d  = res_index_q;
    res_adm_d    = res_adm_q;
    res_ev_d     = res_ev_q;
    res_ev_idx_d = res_ev_idx_q;
    ram_we       = 1'b0;
    ram_waddr    = min_slot_q;
    ram_wdata    = {idx, score_q};
    ram_re       = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            filled_d    = '0;
            cnt_d       = '0;
            min_slot_d  = '0;
            min_score_d = '0;
          end
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_index_d  = '0;
        res_adm_d    = 1'b0;
        res_ev_d     = 1'b0;
        res_ev_idx_d = '0;
        state_d      = ST_DONE;
        if (!cnt_q[INDEX_BITS]) begin
          cnt_d       = cnt_q + 1'b1;
          res_index_d = idx_ext[OUT_IDX_W-1:0];
          if (filled_q < k_eff) begin
            ram_we    = 1'b1;
            ram_waddr = filled_q[SLOT_W-1:0];
            // a newcomer has the largest index: only a strictly lower score moves the minimum
            if ((filled_q == '0) || score_less(score_q, min_score_q)) begin
              min_slot_d  = filled_q[SLOT_W-1:0];
              min_score_d = score_q;
              min_item_d  = idx;
            end
            filled_d  = filled_q + 1'b1;
            res_adm_d = 1'b1;
          end else if (score_less(min_score_q, score_q)) begin
            ram_we       = 1'b1;
            ram_waddr    = min_slot_q;
            res_adm_d    = 1'b1;
            res_ev_d     = 1'b1;
            res_ev_idx_d = min_item_ext[OUT_IDX_W-1:0];
            issue_d      = '0;
            best_any_d   = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read a cycle, compare the returning entry against the running minimum
        if (issue_q < filled_q) begin
          ram_re     = 1'b1;
          rd_valid_d = 1'b1;
          rd_slot_d  = issue_q[SLOT_W-1:0];
          issue_d    = issue_q + 1'b1;
        end
        if (rd_valid_q) begin
          best_any_d = 1'b1;
          if (take) begin
            min_slot_d  = rd_slot_q;
            min_score_d = rd_score;
            min_item_d  = rd_item;
          end
        end else if (issue_q == filled_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= KEEP_RESET;
      filled_q    <= '0;
      cnt_q       <= '0;
      min_slot_q  <= '0;
      min_score_q <= '0;
      min_item_q  <= '0;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      best_any_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      cnt_q       <= cnt_d;
      min_slot_q  <= min_slot_d;
      min_score_q <= min_score_d;
      min_item_q  <= min_item_d;
      issue_q     <= issue_d;
      rd_valid_q  <= rd_valid_d;
      best_any_q  <= best_any_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        keep_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      score_q <= s_axis_tdata;
    end
    rd_slot_q    <= rd_slot_d;
    res_index_q  <= res_index_d;
    res_adm_q    <= res_adm_d;
    res_ev_q     <= res_ev_d;
    res_ev_idx_q <= res_ev_idx_d;
    if ((state_q == ST_DONE) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {{(OUT_DATA_W - 2 * OUT_IDX_W - 2){1'b0}},
                     res_ev_idx_q, res_ev_q, res_adm_q, res_index_q};
    end
  end

  tksel_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEEP)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_q[SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- verif/tb_streaming_top_k_score_selector.sv -----
module tb_streaming_top_k_score_selector;
  import tksel_pkg::*;

  localparam int unsigned KEEP_MAX    = 64;
  localparam int unsigned INDEX_LIMIT = 1 << 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = KEEP_MAX + 16;

  typedef struct packed {
    score_t score;
    logic   restart;
  } score_req_t;

  typedef struct packed {
    out_idx_t item_index;
    logic     admitted;
    logic     evicted_valid;
    out_idx_t evicted_index;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  score_t                s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [KEEP_W-1:0]     cfg_data_i = '0;

  streaming_top_k_score_selector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // selector state as the block should hold it
  score_t            kept_score [KEEP_MAX];
  out_idx_t          kept_index [KEEP_MAX];
  int unsigned       held = 0;
  logic [16:0]       arrivals = '0;
  int unsigned       low_slot = 0;
  score_t            low_score = '0;
  logic [KEEP_W-1:0] keep_k = KEEP_RESET;

  score_req_t  score_requests [$];
  verdict_t    verdicts [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  logic        idle_on = 1'b1;
  logic        req_taken = 1'b0;
  logic        res_taken = 1'b0;

  function automatic verdict_t rank_score(score_t sc, logic restart);
    verdict_t    r;
    int unsigned k;
    int unsigned best;
    k = keep_k;
    if (k == 0) k = 1;
    if (k > KEEP_MAX) k = KEEP_MAX;
    if (restart) begin
      held = 0;
      arrivals = '0;
      low_slot = 0;
      low_score = '0;
    end
    r = '0;
    // refuse once every index has been handed out
    if (arrivals >= INDEX_LIMIT) return r;
    r.item_index = arrivals[15:0];
    arrivals++;
    if (held < k) begin
      kept_score[held] = sc;
      kept_index[held] = r.item_index;
      if (held == 0 || $signed(sc) < $signed(low_score)) begin
        low_slot = held;
        low_score = sc;
      end
      held++;
      r.admitted = 1'b1;
    end else if ($signed(low_score) < $signed(sc)) begin
      r.admitted = 1'b1;
      r.evicted_valid = 1'b1;
      r.evicted_index = kept_index[low_slot];
      kept_score[low_slot] = sc;
      kept_index[low_slot] = r.item_index;
      best = 0;
      for (int unsigned s = 1; s < held; s++) begin
        if ($signed(kept_score[s]) < $signed(kept_score[best]) ||
            (kept_score[s] == kept_score[best] && kept_index[s] < kept_index[best]))
          best = s;
      end
      low_slot = best;
      low_score = kept_score[best];
    end
    return r;
  endfunction

  task automatic check_field(string label, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    score_req_t req;
    if (rst_ni) begin
      if (req_taken && idle_on) send_gap = $urandom_range(0, 5);
      if (s_axis_tvalid && !req_taken) begin
        // hold the current request
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (score_requests.size() > 0) begin
        req = score_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req.score;
        s_axis_tuser <= req.restart;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken && idle_on) take_gap = $urandom_range(0, 5);
      if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    verdict_t want;
    logic     busy;
    req_taken <= s_axis_tvalid && s_axis_tready;
    res_taken <= m_axis_tvalid && m_axis_tready;
    busy = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        keep_k = cfg_data_i;
        busy = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdicts.insert(verdicts.size(), rank_score(s_axis_tdata, s_axis_tuser));
        busy = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = verdicts.pop_front();
          check_field("item_index", want.item_index, m_axis_tdata[15:0]);
          check_field("admitted", 16'(want.admitted), 16'(m_axis_tdata[16]));
          check_field("evicted_valid", 16'(want.evicted_valid), 16'(m_axis_tdata[17]));
          check_field("evicted_index", want.evicted_index, m_axis_tdata[33:18]);
          check_field("padding", 16'h0, 16'(m_axis_tdata[OUT_DATA_W-1:34]));
        end
      end
    end
    if (busy) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic add_item(score_t sc, logic restart);
    score_req_t req;
    req.score = sc;
    req.restart = restart;
    score_requests.insert(score_requests.size(), req);
  endtask

  task automatic settle();
    while (score_requests.size() > 0 || s_axis_tvalid || verdicts.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_keep(logic [KEEP_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic score_t draw_score(int unsigned mode, int unsigned step);
    case (mode)
      0: return score_t'($urandom);
      // narrow band forces equal scores
      1: return score_t'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h7FFF_FFFE;
          default: return 32'h8000_0001;
        endcase
      end
      // rising trend: nearly every item evicts
      default: return score_t'(step * 1000 + $urandom_range(0, 999));
    endcase
  endfunction

  initial begin
    logic [KEEP_W-1:0] kv;
    int unsigned       mode;
    logic              carry_on;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of K, field extremes
    add_item(32'h0000_0000, 1'b1);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'h0000_0001, 1'b0);
    settle();

    // K of zero acts as one; equal score is refused
    write_keep(7'd0);
    add_item(32'd5, 1'b1);
    add_item(32'd5, 1'b0);
    add_item(32'd3, 1'b0);
    add_item(32'd6, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b0);
    settle();

    // tied minima: the oldest goes first
    write_keep(7'd3);
    add_item(32'd10, 1'b1);
    add_item(32'd10, 1'b0);
    add_item(32'd10, 1'b0);
    add_item(32'd11, 1'b0);
    add_item(32'd12, 1'b0);
    settle();

    // shrink K below the fill level without a restart
    write_keep(7'd2);
    add_item(32'd10, 1'b0);
    add_item(32'd13, 1'b0);
    settle();

    // K above the store size, grown without a restart
    write_keep(7'd127);
    add_item(-32'sd5, 1'b0);
    add_item(32'd0, 1'b0);
    add_item(32'd9, 1'b0);
    settle();

    for (int unsigned ph = 0; ph < 8; ph++) begin
      case (ph)
        0: kv = 7'd1;
        1: kv = 7'd2;
        2: kv = 7'd8;
        3: kv = KEEP_W'($urandom_range(3, 63));
        4: kv = 7'd64;
        5: kv = KEEP_W'($urandom_range(65, 127));
        6: kv = 7'd0;
        default: kv = KEEP_W'($urandom_range(1, 64));
      endcase
      idle_on = (ph != 2 && ph != 6);
      carry_on = (ph == 3 || ph == 5 || ph == 6);
      write_keep(kv);
      for (int unsigned i = 0; i < 66; i++) begin
        mode = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : ph % 4;
        add_item(draw_score(mode, i),
                 (i == 0 && !carry_on) || $urandom_range(0, 59) == 0);
      end
      settle();
    end

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
